FILE: hdl/priority_table_with_promote_macros.svh
// Assertion shorthands for the priority table; clocked on i_clk, off during reset.
`ifndef PRIORITY_TABLE_WITH_PROMOTE_MACROS_SVH
`define PRIORITY_TABLE_WITH_PROMOTE_MACROS_SVH

// Same-cycle implication
`define PTWP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptwp: same-cycle check failed");

// Next-cycle implication
`define PTWP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptwp: next-cycle check failed");

`endif

FILE: hdl/ptwp_pkg.sv
package ptwp_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 6;
    localparam int PRI_W    = 16;
    localparam int PAY_W    = 32;

    localparam logic [PRI_W-1:0] PRI_MAX = {PRI_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_PROMOTE = 2'd1,
        OP_POP     = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_ID  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ACC   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FETCH = 4'b1000
    } t_state;

endpackage

FILE: hdl/ptwp_ram.sv
module ptwp_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/priority_table_with_promote.sv
// Indexed max-priority table with promote.
// Request channel: the caller drives i_op, i_entry_id and i_payload_in and raises
// start; a request is taken at a rising edge with start high and busy low.
// Result channel: o_valid is high for exactly one cycle with all result ports;
// the receiver must take it then, it cannot stall the block.
// Steps from the accepting edge to the o_valid cycle:
//   add, and pop of an empty table: the result registers at the accepting edge
//   promote, query: one priority/payload memory read (state S_ACC)
//   pop: the new maximum is found by reading every entry of the priority
//   memory, one per cycle (S_SCAN), then the winner's payload is read from the
//   payload memory (S_FETCH); that read is skipped when the pop removes the
//   last live entry.
// busy is high from the accepting edge until the result cycle (add and an empty
// pop never raise it), so one request is in flight at a time. The current
// maximum is held in registers, so only a pop pays for the scan.
// Reset (synchronous, i_rst_n low) empties the table: all live flags clear,
// the id counter returns to 0 and no maximum is present. Memory contents are
// not cleared; an entry is read only while live.
`include "priority_table_with_promote_macros.svh"

module priority_table_with_promote (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  ptwp_pkg::t_op          i_op,
    input  logic [ptwp_pkg::ID_W-1:0]  i_entry_id,
    input  logic [ptwp_pkg::PAY_W-1:0] i_payload_in,
    output logic                   o_valid,
    output logic [ptwp_pkg::ID_W-1:0]  o_new_id,
    output ptwp_pkg::t_status      o_status,
    output logic                   o_entry_live,
    output logic [ptwp_pkg::PAY_W-1:0] o_entry_payload,
    output logic [ptwp_pkg::PRI_W-1:0] o_entry_priority,
    output logic                   o_max_present,
    output logic [ptwp_pkg::ID_W-1:0]  o_max_entry_id,
    output logic [ptwp_pkg::PRI_W-1:0] o_max_priority,
    output logic [ptwp_pkg::PAY_W-1:0] o_max_payload
);

    import ptwp_pkg::*;

    t_state              r_state;
    t_op                 r_op;
    logic [ID_W-1:0]     r_id;
    logic [CAPACITY-1:0] r_live;
    logic [CNT_W-1:0]    r_next_free;

    // Current maximum
    logic                r_max_vld;
    logic [IDX_W-1:0]    r_max_id;
    logic [PRI_W-1:0]    r_max_pri;
    logic [PAY_W-1:0]    r_max_pay;

    // Scan of the priority memory
    logic [CNT_W-1:0]    r_scan_idx;
    logic                r_scan_vld;
    logic [IDX_W-1:0]    r_scan_pidx;
    logic                r_best_found;
    logic [IDX_W-1:0]    r_best_id;
    logic [PRI_W-1:0]    r_best_pri;

    // Result registers
    logic                r_done;
    logic [ID_W-1:0]     r_new_id;
    t_status             r_status;
    logic                r_e_live;
    logic [PAY_W-1:0]    r_e_pay;
    logic [PRI_W-1:0]    r_e_pri;

    // Memory ports
    logic                pri_we;
    logic [IDX_W-1:0]    pri_waddr;
    logic [PRI_W-1:0]    pri_wdata;
    logic [IDX_W-1:0]    pri_raddr;
    logic [PRI_W-1:0]    pri_rd;
    logic                pay_we;
    logic [IDX_W-1:0]    pay_raddr;
    logic [PAY_W-1:0]    pay_rd;

    logic                accept;
    logic                full;
    logic [IDX_W-1:0]    add_idx;
    logic [IDX_W-1:0]    acc_idx;
    logic                acc_live;
    logic [PRI_W-1:0]    prom_pri;
    logic                prom_take;
    logic                scan_end;
    logic                scan_better;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state != S_IDLE);
    assign full    = (r_next_free >= CNT_W'(CAPACITY));
    assign add_idx = r_next_free[IDX_W-1:0];
    assign acc_idx = IDX_W'(r_id);

    // Check the addressed id and form the promoted priority
    assign acc_live  = ({1'b0, r_id} < (ID_W + 1)'(CAPACITY)) && r_live[acc_idx];
    assign prom_pri  = (pri_rd == PRI_MAX) ? pri_rd : pri_rd + 1'b1;
    assign prom_take = (r_max_id != acc_idx)
                       && ((prom_pri > r_max_pri)
                           || ((prom_pri == r_max_pri) && (acc_idx > r_max_id)));

    // Scan bookkeeping
    assign scan_end    = (r_scan_idx == CNT_W'(CAPACITY)) && !r_scan_vld;
    assign scan_better = r_scan_vld && r_live[r_scan_pidx]
                         && (!r_best_found || (pri_rd >= r_best_pri));

    // Steer memory ports by state
    always_comb begin
        pri_we    = 1'b0;
        pri_waddr = add_idx;
        pri_wdata = '0;
        pay_we    = 1'b0;
        pri_raddr = r_scan_idx[IDX_W-1:0];
        pay_raddr = r_best_id;
        if (r_state == S_IDLE) begin
            pri_raddr = IDX_W'(i_entry_id);
            pay_raddr = IDX_W'(i_entry_id);
            if (accept && (i_op == OP_ADD) && !full) begin
                pri_we = 1'b1;
                pay_we = 1'b1;
            end
        end else if (r_state == S_ACC) begin
            pri_waddr = acc_idx;
            pri_wdata = prom_pri;
            pri_we    = (r_op == OP_PROMOTE) && acc_live;
        end
    end

    ptwp_ram #(.WIDTH(PRI_W), .DEPTH(CAPACITY)) u_pri_ram (
        .i_clk   (i_clk),
        .i_we    (pri_we),
        .i_waddr (pri_waddr),
        .i_wdata (pri_wdata),
        .i_raddr (pri_raddr),
        .o_rdata (pri_rd)
    );

    ptwp_ram #(.WIDTH(PAY_W), .DEPTH(CAPACITY)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (add_idx),
        .i_wdata (i_payload_in),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rd)
    );

    // Control, live flags and current maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_live       <= '0;
            r_next_free  <= '0;
            r_max_vld    <= 1'b0;
            r_done       <= 1'b0;
            r_scan_vld   <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= i_op;
                        r_id     <= i_entry_id;
                        r_new_id <= '0;
                        r_status <= ST_OK;
                        r_e_live <= 1'b0;
                        r_e_pay  <= '0;
                        r_e_pri  <= '0;
                        unique case (i_op)
                            OP_ADD: begin
                                r_done <= 1'b1;
                                if (full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_live[add_idx] <= 1'b1;
                                    r_next_free     <= r_next_free + 1'b1;
                                    r_new_id        <= ID_W'(add_idx);
                                    // New entry wins only against an all-zero table
                                    if (!r_max_vld || (r_max_pri == '0)) begin
                                        r_max_vld <= 1'b1;
                                        r_max_id  <= add_idx;
                                        r_max_pri <= '0;
                                        r_max_pay <= i_payload_in;
                                    end
                                end
                            end
                            OP_PROMOTE, OP_QUERY: begin
                                r_state <= S_ACC;
                            end
                            OP_POP: begin
                                if (!r_max_vld) begin
                                    r_status <= ST_EMPTY;
                                    r_done   <= 1'b1;
                                end else begin
                                    // Return the held maximum, drop it, rescan
                                    r_e_pay          <= r_max_pay;
                                    r_e_pri          <= r_max_pri;
                                    r_live[r_max_id] <= 1'b0;
                                    r_scan_idx       <= '0;
                                    r_scan_vld       <= 1'b0;
                                    r_best_found     <= 1'b0;
                                    r_state          <= S_SCAN;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ACC: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (!acc_live) begin
                        r_status <= ST_BAD_ID;
                    end else if (r_op == OP_QUERY) begin
                        r_e_live <= 1'b1;
                        r_e_pay  <= pay_rd;
                        r_e_pri  <= pri_rd;
                    end else if (r_max_id == acc_idx) begin
                        r_max_pri <= prom_pri;
                    end else if (prom_take) begin
                        r_max_id  <= acc_idx;
                        r_max_pri <= prom_pri;
                        r_max_pay <= pay_rd;
                    end
                end
                S_SCAN: begin
                    // Issue one read a cycle, compare the word that returns
                    if (r_scan_idx != CNT_W'(CAPACITY)) begin
                        r_scan_vld  <= 1'b1;
                        r_scan_pidx <= r_scan_idx[IDX_W-1:0];
                        r_scan_idx  <= r_scan_idx + 1'b1;
                    end else begin
                        r_scan_vld <= 1'b0;
                    end
                    if (scan_better) begin
                        r_best_found <= 1'b1;
                        r_best_id    <= r_scan_pidx;
                        r_best_pri   <= pri_rd;
                    end
                    if (scan_end) begin
                        if (r_best_found) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_max_vld <= 1'b0;
                            r_done    <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_FETCH: begin
                    r_max_vld <= 1'b1;
                    r_max_id  <= r_best_id;
                    r_max_pri <= r_best_pri;
                    r_max_pay <= pay_rd;
                    r_done    <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Drive result ports; maximum fields read zero when the table is empty
    assign o_valid          = r_done;
    assign o_new_id         = r_new_id;
    assign o_status         = r_status;
    assign o_entry_live     = r_e_live;
    assign o_entry_payload  = r_e_pay;
    assign o_entry_priority = r_e_pri;
    assign o_max_present    = r_max_vld;
    assign o_max_entry_id   = r_max_vld ? ID_W'(r_max_id) : '0;
    assign o_max_priority   = r_max_vld ? r_max_pri : '0;
    assign o_max_payload    = r_max_vld ? r_max_pay : '0;

    // Checks
    `PTWP_ASSERT_NXT(a_accept_progress, accept, busy || o_valid)
    `PTWP_ASSERT_IMP(a_count_bound, 1'b1, r_next_free <= CNT_W'(CAPACITY))
    `PTWP_ASSERT_IMP(a_max_is_live, (r_state == S_IDLE) && r_max_vld, r_live[r_max_id])
    `PTWP_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(r_state))

endmodule

FILE: verif/priority_table_with_promote_test.sv
`timescale 1ns / 1ps

module priority_table_with_promote_test;
    import ptwp_pkg::*;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        int               gap;
    } t_table_request;

    typedef struct packed {
        logic [ID_W-1:0]  new_id;
        t_status          status;
        logic             live;
        logic [PAY_W-1:0] entry_pay;
        logic [PRI_W-1:0] entry_pri;
        logic             present;
        logic [ID_W-1:0]  top_id;
        logic [PRI_W-1:0] top_pri;
        logic [PAY_W-1:0] top_pay;
    } t_table_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_op              i_op = OP_ADD;
    logic [ID_W-1:0]  i_entry_id = '0;
    logic [PAY_W-1:0] i_payload_in = '0;
    logic             o_valid;
    logic [ID_W-1:0]  o_new_id;
    t_status          o_status;
    logic             o_entry_live;
    logic [PAY_W-1:0] o_entry_payload;
    logic [PRI_W-1:0] o_entry_priority;
    logic             o_max_present;
    logic [ID_W-1:0]  o_max_entry_id;
    logic [PRI_W-1:0] o_max_priority;
    logic [PAY_W-1:0] o_max_payload;

    // Requests waiting to be driven and results waiting to arrive
    t_table_request pending_requests[$];
    t_table_result  expected_results[$];

    // Shadow copy of the table
    logic             shadow_live [CAPACITY];
    logic [PRI_W-1:0] shadow_pri [CAPACITY];
    logic [PAY_W-1:0] shadow_pay [CAPACITY];
    int               shadow_next;

    // Driver state
    t_table_request staged_req;
    logic           staged = 1'b0;
    int             idle_left = 0;

    // Bookkeeping
    int errors = 0;
    int requests_queued = 0;
    int requests_taken = 0;
    int results_compared = 0;
    int adds_queued = 0;
    int quiet = 0;
    int op_count [4];
    int full_adds = 0;
    int empty_pops = 0;
    int bad_ids = 0;
    int top_holds = 0;

    priority_table_with_promote dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_entry_id       (i_entry_id),
        .i_payload_in     (i_payload_in),
        .o_valid          (o_valid),
        .o_new_id         (o_new_id),
        .o_status         (o_status),
        .o_entry_live     (o_entry_live),
        .o_entry_payload  (o_entry_payload),
        .o_entry_priority (o_entry_priority),
        .o_max_present    (o_max_present),
        .o_max_entry_id   (o_max_entry_id),
        .o_max_priority   (o_max_priority),
        .o_max_payload    (o_max_payload)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Find the live entry with the highest priority; the larger id wins a tie
    function automatic logic find_top(output int where);
        logic found;
        int   i;
        found = 1'b0;
        where = 0;
        for (i = 0; i < CAPACITY; i++) begin
            if (shadow_live[i] && (!found || shadow_pri[i] >= shadow_pri[where])) begin
                where = i;
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Apply one request to the shadow table and return the result it gives
    function automatic t_table_result apply_request(t_table_request r);
        t_table_result res;
        int            top;
        res = '0;
        res.status = ST_OK;
        op_count[r.op]++;
        case (r.op)
            OP_ADD: begin
                if (shadow_next >= CAPACITY) begin
                    res.status = ST_FULL;
                    full_adds++;
                end else begin
                    shadow_pay[shadow_next] = r.pay;
                    shadow_pri[shadow_next] = '0;
                    shadow_live[shadow_next] = 1'b1;
                    res.new_id = ID_W'(shadow_next);
                    shadow_next++;
                end
            end
            OP_PROMOTE: begin
                if (!shadow_live[r.id]) begin
                    res.status = ST_BAD_ID;
                    bad_ids++;
                end else if (shadow_pri[r.id] == PRI_MAX) begin
                    top_holds++;
                end else begin
                    shadow_pri[r.id] = shadow_pri[r.id] + 1'b1;
                end
            end
            OP_POP: begin
                if (!find_top(top)) begin
                    res.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    res.entry_pay = shadow_pay[top];
                    res.entry_pri = shadow_pri[top];
                    shadow_live[top] = 1'b0;
                end
            end
            default: begin
                if (!shadow_live[r.id]) begin
                    res.status = ST_BAD_ID;
                    bad_ids++;
                end else begin
                    res.live = 1'b1;
                    res.entry_pay = shadow_pay[r.id];
                    res.entry_pri = shadow_pri[r.id];
                end
            end
        endcase
        // Every result shows the maximum as it stands after the request
        if (find_top(top)) begin
            res.present = 1'b1;
            res.top_id = ID_W'(top);
            res.top_pri = shadow_pri[top];
            res.top_pay = shadow_pay[top];
        end
        return res;
    endfunction

    // Drive requests: hold start until taken, then idle for the next request's gap
    always @(posedge i_clk) begin : drive_requests
        logic taken;
        int   i;
        if (!i_rst_n) begin
            start <= 1'b0;
            shadow_next = 0;
            for (i = 0; i < CAPACITY; i++) shadow_live[i] = 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                expected_results = {expected_results, apply_request(staged_req)};
                requests_taken++;
            end
            if (taken || !start) begin
                if (!staged && pending_requests.size() != 0) begin
                    staged_req = pending_requests.pop_front();
                    staged = 1'b1;
                    idle_left = staged_req.gap;
                end
                if (staged && idle_left == 0) begin
                    i_op <= staged_req.op;
                    i_entry_id <= staged_req.id;
                    i_payload_in <= staged_req.pay;
                    start <= 1'b1;
                    staged = 1'b0;
                end else begin
                    if (staged) idle_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_table_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding: expected none, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                results_compared++;
                check_field("new_id", 32'(want.new_id), 32'(o_new_id));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("entry_live", 32'(want.live), 32'(o_entry_live));
                check_field("entry_payload", want.entry_pay, o_entry_payload);
                check_field("entry_priority", 32'(want.entry_pri), 32'(o_entry_priority));
                check_field("max_present", 32'(want.present), 32'(o_max_present));
                check_field("max_entry_id", 32'(want.top_id), 32'(o_max_entry_id));
                check_field("max_priority", 32'(want.top_pri), 32'(o_max_priority));
                check_field("max_payload", want.top_pay, o_max_payload);
            end
        end
    end

    // Mostly short gaps, a few long ones, and quiet stretches with none
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 70);
        return $urandom_range(71, 300);
    endfunction

    // Favor ids that have been handed out, unless any id is wanted
    function automatic int pick_id(logic any_id);
        int span;
        span = (adds_queued > CAPACITY) ? CAPACITY : adds_queued;
        if (!any_id && span > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, span - 1);
        return $urandom_range(0, (1 << ID_W) - 1);
    endfunction

    task automatic queue_request(t_op op, int id, logic [PAY_W-1:0] pay, int gap);
        t_table_request r;
        r.op = op;
        r.id = ID_W'(id);
        r.pay = pay;
        r.gap = gap;
        pending_requests = {pending_requests, r};
        requests_queued++;
        if (op == OP_ADD) adds_queued++;
    endtask

    task automatic queue_random(int count, int add_w, int promote_w, int pop_w, logic any_id);
        int  i;
        int  roll;
        t_op op;
        for (i = 0; i < count; i++) begin
            if (i % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < add_w) op = OP_ADD;
            else if (roll < add_w + promote_w) op = OP_PROMOTE;
            else if (roll < add_w + promote_w + pop_w) op = OP_POP;
            else op = OP_QUERY;
            queue_request(op, pick_id(any_id), $urandom, pick_gap());
        end
    endtask

    initial begin : stimulus
        int i;
        int top_slot;

        // Empty table: pop, and requests to ids never added
        queue_request(OP_POP, 0, 32'h0, pick_gap());
        queue_request(OP_QUERY, 0, 32'hFFFF_FFFF, pick_gap());
        queue_request(OP_QUERY, 63, 32'h0, pick_gap());
        queue_request(OP_PROMOTE, 0, 32'h0, pick_gap());
        queue_request(OP_PROMOTE, 63, 32'hFFFF_FFFF, pick_gap());

        // Payload extremes, then read them back
        queue_request(OP_ADD, 63, 32'h0, pick_gap());
        queue_request(OP_ADD, 0, 32'hFFFF_FFFF, pick_gap());
        queue_request(OP_ADD, 63, 32'hA5A5_5A5A, pick_gap());
        queue_request(OP_QUERY, 0, 32'h0, pick_gap());
        queue_request(OP_QUERY, 1, 32'h0, pick_gap());
        queue_request(OP_QUERY, 2, 32'h0, pick_gap());
        queue_request(OP_QUERY, 63, 32'h0, pick_gap());

        // Raise priorities, pop, then touch the popped id
        queue_request(OP_PROMOTE, 0, 32'h0, pick_gap());
        queue_request(OP_PROMOTE, 0, 32'h0, pick_gap());
        queue_request(OP_PROMOTE, 1, 32'h0, pick_gap());
        queue_request(OP_POP, 0, 32'h0, pick_gap());
        queue_request(OP_QUERY, 0, 32'h0, pick_gap());
        queue_request(OP_PROMOTE, 0, 32'h0, pick_gap());
        queue_request(OP_POP, 0, 32'h0, pick_gap());
        queue_request(OP_POP, 0, 32'h0, pick_gap());
        queue_request(OP_POP, 0, 32'h0, pick_gap());

        // Raise one new entry back to back, read it, then pop it
        top_slot = adds_queued;
        queue_request(OP_ADD, 0, $urandom, 0);
        for (i = 0; i < 8; i++) queue_request(OP_PROMOTE, top_slot, $urandom, 0);
        queue_request(OP_QUERY, top_slot, 32'h0, 0);
        queue_request(OP_POP, 0, 32'h0, 0);

        // Fill the table while priorities build up, pop more than is added, then noise
        queue_random(830, 15, 55, 3, 1'b0);
        queue_random(750, 5, 45, 6, 1'b0);
        queue_random(250, 25, 25, 25, 1'b1);

        // Wait for every request to be taken and answered
        do @(posedge i_clk);
        while (requests_taken < requests_queued || expected_results.size() != 0);
        repeat (80) @(posedge i_clk);

        $display("Covered %0d requests (%0d add, %0d promote, %0d pop, %0d query), %0d results compared.",
                 requests_taken, op_count[OP_ADD], op_count[OP_PROMOTE], op_count[OP_POP],
                 op_count[OP_QUERY], results_compared);
        $display("Corner hits: %0d adds to a full table, %0d empty pops, %0d bad ids, %0d top holds.",
                 full_adds, empty_pops, bad_ids, top_holds);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
